// ----- src/rsy_pkg.sv -----
// Package for the rotate/scale YUV 4:2:0 address generator.
// Holds beat types, the pipeline record types, register codes and widths.
// No dependencies.
package rsy_pkg;

  localparam int COORD_W     = 12;
  localparam int DIM_W       = 13;
  localparam int STRIDE_W    = 15;
  localparam int PSTRIDE_W   = 2;
  localparam int ROT_W       = 2;
  localparam int PROD_W      = COORD_W + DIM_W;
  localparam int QUOT_W      = COORD_W;
  localparam int BIT_IDX_W   = $clog2(QUOT_W);
  localparam int IDX_SUM_W   = 24;
  localparam int LUMA_W      = 26;
  localparam int CHROMA_W    = 25;
  localparam int INDEX_W     = 26;
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_INDEX_W = 3;
  localparam int MAX_DIM     = 4096;
  localparam int LUMA_PIXEL_STEP = 1;
  localparam int NSTG        = QUOT_W + 3;

  localparam logic [DIM_W-1:0]     SRC_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0]     SRC_HEIGHT_RST = DIM_W'(480);
  localparam logic [DIM_W-1:0]     OUT_WIDTH_RST  = DIM_W'(320);
  localparam logic [DIM_W-1:0]     OUT_HEIGHT_RST = DIM_W'(320);
  localparam logic [STRIDE_W-1:0]  LUMA_RS_RST    = STRIDE_W'(640);
  localparam logic [STRIDE_W-1:0]  CHROMA_RS_RST  = STRIDE_W'(320);
  localparam logic [PSTRIDE_W-1:0] CHROMA_PS_RST  = PSTRIDE_W'(1);

  typedef enum logic [ROT_W-1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SRC_WIDTH      = 3'd0,
    REG_SRC_HEIGHT     = 3'd1,
    REG_ROTATION       = 3'd2,
    REG_OUT_WIDTH      = 3'd3,
    REG_OUT_HEIGHT     = 3'd4,
    REG_LUMA_ROW_STR   = 3'd5,
    REG_CHROMA_ROW_STR = 3'd6,
    REG_CHROMA_PIX_STR = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
  } in_beat_t;

  typedef struct packed {
    logic [LUMA_W-1:0]   luma_offset;
    logic [CHROMA_W-1:0] chroma_offset;
    logic [INDEX_W-1:0]  out_index;
  } out_beat_t;

  typedef struct packed {
    logic [DIM_W-1:0]     w;
    logic [DIM_W-1:0]     h;
    logic [DIM_W-1:0]     tw;
    logic [DIM_W-1:0]     th;
    rot_e                 rot;
    logic [STRIDE_W-1:0]  luma_row_stride;
    logic [STRIDE_W-1:0]  chroma_row_stride;
    logic [PSTRIDE_W-1:0] chroma_pixel_stride;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] ox;
    logic [PROD_W-1:0]  rem_x;
    logic [PROD_W-1:0]  rem_y;
    logic [QUOT_W-1:0]  q_x;
    logic [QUOT_W-1:0]  q_y;
    logic               clamp_x;
    logic               clamp_y;
    logic [PROD_W-1:0]  idx;
  } div_t;

  typedef struct packed {
    logic [COORD_W-1:0]   sx;
    logic [COORD_W-1:0]   sy;
    logic [IDX_SUM_W-1:0] idx_sum;
  } map_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic logic rot_swaps(input rot_e rot);
    return (rot == ROT_90) || (rot == ROT_270);
  endfunction

endpackage

// ----- src/rotate_scale_yuv420_address_gen_top.sv -----
// Rotated nearest-neighbour resize address generator for a YUV 4:2:0 frame.
// One output pixel coordinate enters per clock unless pix_stall is high, and its
// luma offset, shared chroma offset and RGB byte index leave the output register,
// one beat per clock while not held. The depth is set by the restoring divider
// that forms floor(out * rotated_size / target_size): twelve stages, one
// quotient bit per stage for each coordinate, behind one product stage and
// ahead of a mapping stage and the output register. Bubbles collapse, so a
// stalled output only holds the pipeline once every stage is full.
// Write configuration only when no beat is in flight; the block does not enforce it.
// Depends on rsy_pkg, rsy_scale, rsy_div_stage and rsy_map.
module rotate_scale_yuv420_address_gen_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rsy_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rsy_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            pix_valid,
  output logic                            pix_stall,
  input  rsy_pkg::in_beat_t               pix,
  output logic                            addr_valid,
  input  logic                            addr_stall,
  output rsy_pkg::out_beat_t              addr
);
  import rsy_pkg::*;

  logic [DIM_W-1:0]     src_width;
  logic [DIM_W-1:0]     src_height;
  rot_e                 rotation;
  logic [DIM_W-1:0]     out_width;
  logic [DIM_W-1:0]     out_height;
  logic [STRIDE_W-1:0]  luma_row_stride;
  logic [STRIDE_W-1:0]  chroma_row_stride;
  logic [PSTRIDE_W-1:0] chroma_pixel_stride;
  cfg_t                 cfg;

  logic [NSTG-1:0]      vld;
  logic [NSTG-1:0]      en;
  div_t                 dpipe [QUOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width           <= SRC_WIDTH_RST;
      src_height          <= SRC_HEIGHT_RST;
      rotation            <= ROT_0;
      out_width           <= OUT_WIDTH_RST;
      out_height          <= OUT_HEIGHT_RST;
      luma_row_stride     <= LUMA_RS_RST;
      chroma_row_stride   <= CHROMA_RS_RST;
      chroma_pixel_stride <= CHROMA_PS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_SRC_WIDTH:      src_width           <= cfg_data[DIM_W-1:0];
        REG_SRC_HEIGHT:     src_height          <= cfg_data[DIM_W-1:0];
        REG_ROTATION:       rotation            <= rot_e'(cfg_data[ROT_W-1:0]);
        REG_OUT_WIDTH:      out_width           <= cfg_data[DIM_W-1:0];
        REG_OUT_HEIGHT:     out_height          <= cfg_data[DIM_W-1:0];
        REG_LUMA_ROW_STR:   luma_row_stride     <= cfg_data[STRIDE_W-1:0];
        REG_CHROMA_ROW_STR: chroma_row_stride   <= cfg_data[STRIDE_W-1:0];
        REG_CHROMA_PIX_STR: chroma_pixel_stride <= cfg_data[PSTRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.w                   = eff_dim(src_width);
    cfg.h                   = eff_dim(src_height);
    cfg.tw                  = eff_dim(out_width);
    cfg.th                  = eff_dim(out_height);
    cfg.rot                 = rotation;
    cfg.luma_row_stride     = luma_row_stride;
    cfg.chroma_row_stride   = chroma_row_stride;
    cfg.chroma_pixel_stride = chroma_pixel_stride;
  end

  // a stage loads unless it and every stage after it are full and the output is held
  for (genvar s = 0; s < NSTG; s++) begin : g_en
    assign en[s] = !((&vld[NSTG-1:s]) && addr_stall);
  end

  assign pix_stall  = !en[0];
  assign addr_valid = vld[NSTG-1];

  rsy_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .en         (en[0]),
    .cfg        (cfg),
    .feed_valid (pix_valid),
    .feed       (pix),
    .valid      (vld[0]),
    .beat       (dpipe[0])
  );

  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    rsy_div_stage u_div (
      .clk        (clk),
      .rst        (rst),
      .en         (en[k+1]),
      .bit_idx    (BIT_IDX_W'(QUOT_W - 1 - k)),
      .cfg        (cfg),
      .feed_valid (vld[k]),
      .feed       (dpipe[k]),
      .valid      (vld[k+1]),
      .beat       (dpipe[k+1])
    );
  end

  rsy_map u_map (
    .clk        (clk),
    .rst        (rst),
    .en         (en[NSTG-1:NSTG-2]),
    .cfg        (cfg),
    .feed_valid (vld[QUOT_W]),
    .feed       (dpipe[QUOT_W]),
    .mid_valid  (vld[NSTG-2]),
    .valid      (vld[NSTG-1]),
    .beat       (addr)
  );

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_stall |=> vld[0])
    else $error("accepted beat did not enter the first stage");

  a_no_stall_with_room: assert property (@(posedge clk) disable iff (rst)
    !vld[NSTG-1] |-> !pix_stall)
    else $error("input stalled while output stage empty");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] && addr_stall && (&vld) |-> pix_stall)
    else $error("input taken while every stage is full and output held");

endmodule

// ----- src/rsy_scale.sv -----
// Entry stage: products of output coordinates with rotated sizes, clamp flags
// and the RGB row product. Depends on rsy_pkg.
module rsy_scale (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rsy_pkg::cfg_t     cfg,
  input  logic              feed_valid,
  input  rsy_pkg::in_beat_t feed,
  output logic              valid,
  output rsy_pkg::div_t     beat
);
  import rsy_pkg::*;

  logic [DIM_W-1:0] rw;
  logic [DIM_W-1:0] rh;
  div_t             beat_next;

  always_comb begin
    rw = rot_swaps(cfg.rot) ? cfg.h : cfg.w;
    rh = rot_swaps(cfg.rot) ? cfg.w : cfg.h;
    beat_next.ox      = feed.out_x;
    beat_next.rem_x   = PROD_W'(feed.out_x) * PROD_W'(rw);
    beat_next.rem_y   = PROD_W'(feed.out_y) * PROD_W'(rh);
    beat_next.q_x     = '0;
    beat_next.q_y     = '0;
    beat_next.clamp_x = DIM_W'(feed.out_x) >= cfg.tw;
    beat_next.clamp_y = DIM_W'(feed.out_y) >= cfg.th;
    beat_next.idx     = PROD_W'(feed.out_y) * PROD_W'(cfg.tw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat <= beat_next;
    end
  end

endmodule

// ----- src/rsy_div_stage.sv -----
// One restoring-division stage: settles one quotient bit for each coordinate.
// Depends on rsy_pkg.
module rsy_div_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [rsy_pkg::BIT_IDX_W-1:0] bit_idx,
  input  rsy_pkg::cfg_t                 cfg,
  input  logic                          feed_valid,
  input  rsy_pkg::div_t                 feed,
  output logic                          valid,
  output rsy_pkg::div_t                 beat
);
  import rsy_pkg::*;

  logic [PROD_W-1:0] dsh_x;
  logic [PROD_W-1:0] dsh_y;
  div_t              beat_next;

  always_comb begin
    dsh_x     = PROD_W'(cfg.tw) << bit_idx;
    dsh_y     = PROD_W'(cfg.th) << bit_idx;
    beat_next = feed;
    if (feed.rem_x >= dsh_x) begin
      beat_next.rem_x        = feed.rem_x - dsh_x;
      beat_next.q_x[bit_idx] = 1'b1;
    end
    if (feed.rem_y >= dsh_y) begin
      beat_next.rem_y        = feed.rem_y - dsh_y;
      beat_next.q_y[bit_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat <= beat_next;
    end
  end

  a_rem_x_bound: assert property (@(posedge clk) disable iff (rst)
    valid && !beat.clamp_x |-> beat.rem_x < dsh_x)
    else $error("x remainder not below shifted divisor");

  a_rem_y_bound: assert property (@(posedge clk) disable iff (rst)
    valid && !beat.clamp_y |-> beat.rem_y < dsh_y)
    else $error("y remainder not below shifted divisor");

endmodule

// ----- src/rsy_map.sv -----
// Back end: clamp, map rotated coordinates to source, then form the luma,
// chroma and RGB byte offsets into the output register. Depends on rsy_pkg.
module rsy_map (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         en,
  input  rsy_pkg::cfg_t      cfg,
  input  logic               feed_valid,
  input  rsy_pkg::div_t      feed,
  output logic               mid_valid,
  output logic               valid,
  output rsy_pkg::out_beat_t beat
);
  import rsy_pkg::*;

  logic [DIM_W-1:0]    rw_m1;
  logic [DIM_W-1:0]    rh_m1;
  logic [DIM_W-1:0]    w_m1;
  logic [DIM_W-1:0]    h_m1;
  logic [COORD_W-1:0]  rx;
  logic [COORD_W-1:0]  ry;
  map_t                mid;
  map_t                mid_next;
  logic [LUMA_W:0]     luma_prod;
  logic [LUMA_W-1:0]   chroma_prod;
  logic [DIM_W-1:0]    chroma_pix;
  out_beat_t           beat_next;

  always_comb begin
    rw_m1 = (rot_swaps(cfg.rot) ? cfg.h : cfg.w) - DIM_W'(1);
    rh_m1 = (rot_swaps(cfg.rot) ? cfg.w : cfg.h) - DIM_W'(1);
    w_m1  = cfg.w - DIM_W'(1);
    h_m1  = cfg.h - DIM_W'(1);
    rx    = feed.clamp_x ? rw_m1[COORD_W-1:0] : feed.q_x;
    ry    = feed.clamp_y ? rh_m1[COORD_W-1:0] : feed.q_y;
    unique case (cfg.rot)
      ROT_0: begin
        mid_next.sx = rx;
        mid_next.sy = ry;
      end
      ROT_90: begin
        mid_next.sx = ry;
        mid_next.sy = h_m1[COORD_W-1:0] - rx;
      end
      ROT_180: begin
        mid_next.sx = w_m1[COORD_W-1:0] - rx;
        mid_next.sy = h_m1[COORD_W-1:0] - ry;
      end
      ROT_270: begin
        mid_next.sx = w_m1[COORD_W-1:0] - ry;
        mid_next.sy = rx;
      end
      default: begin
        mid_next.sx = rx;
        mid_next.sy = ry;
      end
    endcase
    mid_next.idx_sum = IDX_SUM_W'(feed.idx + PROD_W'(feed.ox));
  end

  always_comb begin
    luma_prod   = (LUMA_W+1)'(mid.sy) * (LUMA_W+1)'(cfg.luma_row_stride);
    chroma_prod = LUMA_W'(mid.sy[COORD_W-1:1]) * LUMA_W'(cfg.chroma_row_stride);
    chroma_pix  = DIM_W'(mid.sx[COORD_W-1:1]) * DIM_W'(cfg.chroma_pixel_stride);
    beat_next.luma_offset   = luma_prod[LUMA_W-1:0]
                              + LUMA_W'(mid.sx) * LUMA_W'(LUMA_PIXEL_STEP);
    beat_next.chroma_offset = chroma_prod[CHROMA_W-1:0] + CHROMA_W'(chroma_pix);
    beat_next.out_index     = INDEX_W'({mid.idx_sum, 1'b0}) + INDEX_W'(mid.idx_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      valid     <= 1'b0;
    end else begin
      if (en[0]) begin
        mid_valid <= feed_valid;
      end
      if (en[1]) begin
        valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mid <= mid_next;
    end
    if (en[1]) begin
      beat <= beat_next;
    end
  end

  a_src_in_frame: assert property (@(posedge clk) disable iff (rst)
    mid_valid |-> (DIM_W'(mid.sx) < cfg.w) && (DIM_W'(mid.sy) < cfg.h))
    else $error("mapped source coordinate outside frame");

endmodule
